// ===== design/kpmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpmd_pkg
// Shared types, register indexes and helpers of the key-frame motion detector.
// ----------------------------------------------------------------------------
package kpmd_pkg;

  localparam int SUM_W  = 28;
  localparam int ERR_W  = 18;
  localparam int FNUM_W = 32;
  localparam int KEY_W  = 16;
  localparam int RC_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SSE_LIMIT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_INTERVAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_COUNT = 2'd2;

  localparam logic [SUM_W-1:0] SSE_LIMIT_RESET       = 28'd53175;
  localparam logic [KEY_W-1:0] KEY_INTERVAL_RESET    = 16'd15;
  localparam logic [RC_W-1:0]  REFERENCE_COUNT_RESET = 3'd2;

  typedef struct packed {
    logic [7:0] chan_blue;
    logic [7:0] chan_green;
    logic [7:0] chan_red;
    logic       end_of_frame;
    logic [FNUM_W-1:0] frame_number;
  } pix_item_t;

  typedef struct packed {
    logic       moved;
    logic [FNUM_W-1:0] frame_number_out;
    logic       stored_as_key;
  } res_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // per-lane control for the accumulate stage
  typedef struct packed {
    logic valid;
    logic acc;
    logic check;
    logic last;
  } lane_ctl_t;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

endpackage

// ===== design/kpmd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpmd_lane
// One reference slot: pixel memory, squared-error stage and saturating
// error accumulator with the end-of-frame limit compare.
// ----------------------------------------------------------------------------
module kpmd_lane #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [$clog2(DEPTH)-1:0]    addr,
  input  logic                        wr_en,
  input  kpmd_pkg::pixel_t            wr_pix,
  input  kpmd_pkg::pixel_t            cmp_pix,
  input  kpmd_pkg::lane_ctl_t         ctl,
  input  logic [kpmd_pkg::SUM_W-1:0]  sse_limit,
  output logic                        over
);
  import kpmd_pkg::*;

  pixel_t            mem [DEPTH];
  pixel_t            ref_pix;
  logic [ERR_W-1:0]  err;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_next;

  // read old contents, then overwrite when this slot stores the frame
  always_ff @(posedge clk) begin
    if (advance) begin
      ref_pix <= mem[addr];
    end
    if (wr_en) begin
      mem[addr] <= wr_pix;
    end
  end

  // squared channel differences
  always_ff @(posedge clk) begin
    if (advance) begin
      err <= ERR_W'(sq_diff(ref_pix.blue, cmp_pix.blue))
           + ERR_W'(sq_diff(ref_pix.green, cmp_pix.green))
           + ERR_W'(sq_diff(ref_pix.red, cmp_pix.red));
    end
  end

  // saturating add
  always_comb begin
    sum_ext  = {1'b0, sum} + (SUM_W + 1)'(err);
    sum_next = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    if (!ctl.acc) begin
      sum_next = sum;
    end
  end

  // accumulate; judge and clear on the last pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (advance && ctl.valid) begin
      if (ctl.last) begin
        sum <= '0;
      end else begin
        sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctl.valid && ctl.last) begin
      over <= ctl.check && (sum_next > sse_limit);
    end
  end

endmodule

// ===== design/keyframe_psnr_motion_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_psnr_motion_detector
// Key-frame motion detector over a stream of thumbnail pixels.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock with no gaps of its own making. Each reference
// slot is a lane with its own pixel memory (one read and one write port at the
// current pixel position) and its own error accumulator, so all references are
// compared in the same cycle. After the last pixel of a frame is accepted, its
// result passes the p1, p2 and p3 pipeline registers and then reaches the
// output register; the lane flags are ORed in the output register. The
// input stalls only while a finished result is waiting in the output register
// and the next result is ready to take its place. Reference pixel memories are
// not cleared: a slot is compared only after a whole frame has been stored in
// it, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module keyframe_psnr_motion_detector #(
  parameter int MAX_REFERENCES = 4,
  parameter int MAX_PIXELS     = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_stall,
  input  kpmd_pkg::pix_item_t               pix,
  output logic                              res_valid,
  input  logic                              res_stall,
  output kpmd_pkg::res_item_t               res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kpmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kpmd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import kpmd_pkg::*;

  localparam int NREF   = MAX_REFERENCES;
  localparam int SLOT_W = (NREF > 1) ? $clog2(NREF) : 1;
  localparam int CNT_W  = $clog2(NREF + 1);
  localparam int ADDR_W = $clog2(MAX_PIXELS);
  localparam int POS_W  = $clog2(MAX_PIXELS + 1);

  // configuration
  logic [SUM_W-1:0] sse_limit;
  logic [KEY_W-1:0] key_interval;
  logic [RC_W-1:0]  reference_count;

  // frame control state
  logic [POS_W-1:0]  pixel_position;
  logic              store_flag;
  logic [SLOT_W-1:0] write_slot;
  logic [FNUM_W-1:0] next_key_index;
  logic [NREF-1:0]   reference_valid;

  logic              advance;
  logic              accept;
  logic [CNT_W-1:0]  count;
  logic              first_pix;
  logic              in_range;
  logic              store_eff;
  logic [SLOT_W-1:0] slot_eff;
  logic [SLOT_W-1:0] slot_next;
  logic [NREF-1:0]   check_mask;

  // pipeline registers
  logic              p1_valid, p1_last, p1_store, p1_acc;
  logic [FNUM_W-1:0] p1_fnum;
  pixel_t            p1_pix;
  logic [NREF-1:0]   p1_check;
  logic              p2_valid, p2_last, p2_store, p2_acc;
  logic [FNUM_W-1:0] p2_fnum;
  logic [NREF-1:0]   p2_check;
  logic              p3_valid, p3_store;
  logic [FNUM_W-1:0] p3_fnum;
  logic [NREF-1:0]   lane_over;

  pixel_t            wr_pix;

  // hold everything only when a new result would overwrite a waiting one
  assign advance   = !(res_valid && res_stall && p3_valid);
  assign pix_stall = !advance;
  assign accept    = pix_valid && advance;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sse_limit       <= SSE_LIMIT_RESET;
      key_interval    <= KEY_INTERVAL_RESET;
      reference_count <= REFERENCE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SSE_LIMIT:       sse_limit       <= cfg_data[SUM_W-1:0];
        REG_KEY_INTERVAL:    key_interval    <= cfg_data[KEY_W-1:0];
        REG_REFERENCE_COUNT: reference_count <= cfg_data[RC_W-1:0];
        default: ;
      endcase
    end
  end

  // effective reference count, saturated to the slot range
  always_comb begin
    if (reference_count == '0) begin
      count = CNT_W'(1);
    end else if (32'(reference_count) > 32'(NREF)) begin
      count = CNT_W'(NREF);
    end else begin
      count = CNT_W'(reference_count);
    end
  end

  // per-pixel decisions
  always_comb begin
    first_pix = (pixel_position == '0);
    in_range  = (32'(pixel_position) < 32'(MAX_PIXELS));
    store_eff = first_pix ? (pix.frame_number >= next_key_index) : store_flag;
    slot_eff  = write_slot;
    if (first_pix && (32'(write_slot) >= 32'(count))) begin
      slot_eff = '0;
    end
    if (32'(slot_eff) + 32'd1 >= 32'(count)) begin
      slot_next = '0;
    end else begin
      slot_next = slot_eff + 1'b1;
    end
    for (int s = 0; s < NREF; s++) begin
      check_mask[s] = reference_valid[s] && (s < 32'(count));
    end
    wr_pix.blue  = pix.chan_blue;
    wr_pix.green = pix.chan_green;
    wr_pix.red   = pix.chan_red;
  end

  // advance frame state on each accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position  <= '0;
      store_flag      <= 1'b0;
      write_slot      <= '0;
      next_key_index  <= '0;
      reference_valid <= '0;
    end else if (accept) begin
      if (pix.end_of_frame) begin
        pixel_position <= '0;
        store_flag     <= 1'b0;
        if (store_eff) begin
          reference_valid[slot_eff] <= 1'b1;
          write_slot                <= slot_next;
          next_key_index            <= pix.frame_number + FNUM_W'(key_interval);
        end else begin
          write_slot <= slot_eff;
        end
      end else begin
        if (in_range) begin
          pixel_position <= pixel_position + 1'b1;
        end
        store_flag <= store_eff;
        write_slot <= slot_eff;
      end
    end
  end

  // pipeline control valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else if (advance) begin
      p1_valid <= pix_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid && p2_last;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      p1_last  <= pix.end_of_frame;
      p1_store <= store_eff;
      p1_acc   <= in_range;
      p1_fnum  <= pix.frame_number;
      p1_pix   <= wr_pix;
      p1_check <= check_mask;
      p2_last  <= p1_last;
      p2_store <= p1_store;
      p2_acc   <= p1_acc;
      p2_fnum  <= p1_fnum;
      p2_check <= p1_check;
      p3_store <= p2_store;
      p3_fnum  <= p2_fnum;
    end
  end

  // one lane per reference slot
  for (genvar s = 0; s < NREF; s++) begin : g_lane
    lane_ctl_t ctl;
    logic      wr_en;

    assign ctl.valid = p2_valid;
    assign ctl.acc   = p2_acc && p2_check[s];
    assign ctl.check = p2_check[s];
    assign ctl.last  = p2_last;
    assign wr_en     = accept && store_eff && in_range && (32'(slot_eff) == s);

    kpmd_lane #(
      .DEPTH(MAX_PIXELS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .addr      (pixel_position[ADDR_W-1:0]),
      .wr_en     (wr_en),
      .wr_pix    (wr_pix),
      .cmp_pix   (p1_pix),
      .ctl       (ctl),
      .sse_limit (sse_limit),
      .over      (lane_over[s])
    );
  end

  // merge lane flags into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && p3_valid) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && p3_valid) begin
      res.moved            <= |lane_over;
      res.frame_number_out <= p3_fnum;
      res.stored_as_key    <= p3_store;
    end
  end

  // checks
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (res_valid && res_stall && p3_valid))
    else $error("input stalled without a blocked result");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pixel_position) <= 32'(MAX_PIXELS))
    else $error("pixel position past frame capacity");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && pix.end_of_frame) |=> (pixel_position == '0) && !store_flag)
    else $error("frame state not cleared after last pixel");

  a_key_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && pix.end_of_frame && store_eff) |=>
      (next_key_index == $past(pix.frame_number + FNUM_W'(key_interval))))
    else $error("next key index not advanced on stored frame");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (advance && p3_valid) |=> res_valid)
    else $error("finished result not presented");

endmodule

// ===== verif/kpmd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpmd_checker
// Watches the pixel, result and register channels of the key-frame motion
// detector, predicts the verdict of every frame and compares it with the
// verdict the block delivers.
// ----------------------------------------------------------------------------
module kpmd_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  input  logic                          pix_stall,
  input  kpmd_pkg::pix_item_t           pix,
  input  logic                          res_valid,
  input  logic                          res_stall,
  input  kpmd_pkg::res_item_t           res,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [kpmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpmd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            judged,
  output int                            moved_seen,
  output int                            keys_seen
);
  import kpmd_pkg::*;

  localparam int SLOTS  = 4;
  localparam int PIXELS = 1024;

  // predicted detector state
  pixel_t           key_pixels [SLOTS*PIXELS];
  logic             key_valid [SLOTS];
  logic [SUM_W-1:0] err_sum [SLOTS];
  int unsigned      pos;
  logic [FNUM_W-1:0] next_key;
  int unsigned      wslot;
  logic             keep_frame;

  // register copies
  logic [SUM_W-1:0] limit_cfg;
  logic [KEY_W-1:0] interval_cfg;
  logic [RC_W-1:0]  count_cfg;

  // verdicts waiting for the block
  res_item_t verdict_q [$];

  function automatic int unsigned live_slots();
    if (count_cfg == 0) return 1;
    if (count_cfg > SLOTS) return SLOTS;
    return 32'(count_cfg);
  endfunction

  function automatic logic [15:0] chan_err(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] gap;
    gap = (a >= b) ? {8'd0, a - b} : {8'd0, b - a};
    return gap * gap;
  endfunction

  // advance the prediction by one pixel; queue a verdict on the last one
  task automatic judge_pixel(input pix_item_t p);
    int unsigned n;
    logic [17:0] e;
    logic [SUM_W:0] acc;
    logic hit;
    pixel_t r;
    res_item_t v;
    n = live_slots();
    if (pos == 0) begin
      keep_frame = p.frame_number >= next_key;
      if (wslot >= n) wslot = 0;
    end
    if (pos < PIXELS) begin
      for (int s = 0; s < n; s++) begin
        if (key_valid[s]) begin
          r = key_pixels[s*PIXELS + pos];
          e = 18'(chan_err(r.blue, p.chan_blue)) + 18'(chan_err(r.green, p.chan_green))
            + 18'(chan_err(r.red, p.chan_red));
          acc = {1'b0, err_sum[s]} + (SUM_W + 1)'(e);
          err_sum[s] = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
        end
      end
      if (keep_frame) begin
        r.blue  = p.chan_blue;
        r.green = p.chan_green;
        r.red   = p.chan_red;
        key_pixels[wslot*PIXELS + pos] = r;
      end
      pos++;
    end
    if (p.end_of_frame) begin
      hit = 1'b0;
      for (int s = 0; s < n; s++) begin
        if (key_valid[s] && err_sum[s] > limit_cfg) hit = 1'b1;
      end
      if (keep_frame) begin
        key_valid[wslot] = 1'b1;
        wslot = (wslot + 1) % n;
        next_key = p.frame_number + FNUM_W'(interval_cfg);
      end
      v.moved            = hit;
      v.frame_number_out = p.frame_number;
      v.stored_as_key    = keep_frame;
      verdict_q.push_back(v);
      for (int s = 0; s < SLOTS; s++) err_sum[s] = '0;
      pos = 0;
      keep_frame = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        key_valid[s] = 1'b0;
        err_sum[s]   = '0;
      end
      pos          = 0;
      next_key     = '0;
      wslot        = 0;
      keep_frame   = 1'b0;
      limit_cfg    = SSE_LIMIT_RESET;
      interval_cfg = KEY_INTERVAL_RESET;
      count_cfg    = REFERENCE_COUNT_RESET;
      verdict_q.delete();
      errors     = 0;
      judged     = 0;
      moved_seen = 0;
      keys_seen  = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SSE_LIMIT:       limit_cfg = cfg_data[SUM_W-1:0];
          REG_KEY_INTERVAL:    interval_cfg = cfg_data[KEY_W-1:0];
          REG_REFERENCE_COUNT: count_cfg = cfg_data[RC_W-1:0];
          default: ;
        endcase
      end
      // pixel transactions
      if (pix_valid && !pix_stall) judge_pixel(pix);
      // result transactions
      if (res_valid && !res_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict: moved=%0d frame=%0d key=%0d",
                   $time, res.moved, res.frame_number_out, res.stored_as_key);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          judged++;
          if (want.moved) moved_seen++;
          if (want.stored_as_key) keys_seen++;
          if (res.moved !== want.moved) begin
            $display("%0t: moved on frame %0d: expected %0d, got %0d",
                     $time, want.frame_number_out, want.moved, res.moved);
            errors++;
          end
          if (res.frame_number_out !== want.frame_number_out) begin
            $display("%0t: frame_number_out: expected %0d, got %0d",
                     $time, want.frame_number_out, res.frame_number_out);
            errors++;
          end
          if (res.stored_as_key !== want.stored_as_key) begin
            $display("%0t: stored_as_key on frame %0d: expected %0d, got %0d",
                     $time, want.frame_number_out, want.stored_as_key, res.stored_as_key);
            errors++;
          end
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ===== verif/keyframe_psnr_motion_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_psnr_motion_detector_tb
// Drives thumbnail frames into the motion detector: two over-length frames,
// a few directed frames (all-zero, exact repeat, all-full), then random
// frames built mostly from repeats and small nudges of the previous frame
// under eight register settings and four pacing modes. The checker beside
// the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module keyframe_psnr_motion_detector_tb;
  import kpmd_pkg::*;

  localparam int PIXEL_SLOTS = 1024;
  localparam int LONG_LEN    = 1027;
  localparam int FRAME_CAP   = 6;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 50;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [2:0] {
    FILL_RANDOM, FILL_EXTREME, FILL_REPEAT, FILL_NUDGE, FILL_LOW, FILL_HIGH
  } fill_e;

  typedef enum logic [1:0] {
    PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH
  } pace_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  pix_item_t pix = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_item_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors, pending, judged, moved_seen, keys_seen;
  int unsigned stall_pct = 0;
  int unsigned gap_pct = 0;
  int unsigned cycles = 0;
  int unsigned pixels_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned settings = 0;

  // stimulus bookkeeping: last frame content, key-frame schedule and the
  // longest frame every stored reference can be compared against
  pixel_t      last_frame [FRAME_CAP];
  logic [31:0] fnum_now = '0;
  logic [31:0] key_due = '0;
  logic [15:0] interval_now = KEY_INTERVAL_RESET;
  int unsigned len_cap = PIXEL_SLOTS;

  keyframe_psnr_motion_detector u_top (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kpmd_checker u_check (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .judged(judged),
    .moved_seen(moved_seen), .keys_seen(keys_seen)
  );

  always #5 clk = ~clk;

  // random receiver back-pressure
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("keyframe_psnr_motion_detector_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[32] ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(2)) - 1;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  function automatic pixel_t make_pixel(input fill_e mode, input pixel_t prev);
    pixel_t c;
    case (mode)
      FILL_LOW:    c = '0;
      FILL_HIGH:   c = '1;
      FILL_REPEAT: c = prev;
      FILL_NUDGE: begin
        c.red   = nudge(prev.red);
        c.green = nudge(prev.green);
        c.blue  = nudge(prev.blue);
      end
      FILL_EXTREME: begin
        c.red   = $urandom_range(1) ? 8'hFF : 8'h00;
        c.green = $urandom_range(1) ? 8'hFF : 8'h00;
        c.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: c = pixel_t'($urandom);
    endcase
    return c;
  endfunction

  // one register transaction; valid stays high for a following write
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write all registers; unused upper data bits carry random junk
  task automatic write_regs(input logic [SUM_W-1:0] lim, input logic [KEY_W-1:0] ivl,
                            input logic [RC_W-1:0] cnt, input bit spare);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    put_reg(REG_SSE_LIMIT, lim);
    put_reg(REG_KEY_INTERVAL, {junk[CFG_DATA_W-1:KEY_W], ivl});
    put_reg(REG_REFERENCE_COUNT, {junk[CFG_DATA_W-1:RC_W], cnt});
    if (spare) put_reg(REG_SPARE, junk);
    cfg_valid <= 1'b0;
    interval_now = ivl;
    settings++;
  endtask

  // one pixel transaction, with optional idle cycles ahead of it
  task automatic push_pixel(input pix_item_t p);
    while ($urandom_range(99) < gap_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix       <= p;
    pix_valid <= 1'b1;
    do @(posedge clk); while (pix_stall);
    pixels_sent++;
  endtask

  // send one frame; a zero length picks one that keeps every compare legal
  task automatic send_frame(input int unsigned len_req, input logic [31:0] first_no,
                            input logic [31:0] last_no, input fill_e mode);
    pix_item_t p;
    pixel_t c;
    pixel_t prev;
    logic keep;
    int unsigned len;
    keep = first_no >= key_due;
    len = len_req;
    if (len == 0) len = keep ? len_cap : $urandom_range(len_cap, 1);
    for (int unsigned i = 0; i < len; i++) begin
      prev = '0;
      if (i < FRAME_CAP) prev = last_frame[i];
      c = make_pixel(mode, prev);
      if (i < FRAME_CAP) last_frame[i] = c;
      p.chan_blue    = c.blue;
      p.chan_green   = c.green;
      p.chan_red     = c.red;
      p.end_of_frame = (i == len - 1);
      p.frame_number = (i == len - 1) ? last_no : first_no;
      push_pixel(p);
    end
    // a kept frame bounds the length of every later frame
    if (keep) begin
      if (len < len_cap) len_cap = len;
      key_due = last_no + 32'(interval_now);
    end
    frames_sent++;
  endtask

  // drop valid, drain every expected verdict, then let the pipeline empty
  task automatic settle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int unsigned mark;
    int unsigned roll;
    logic [31:0] first_no;
    logic [31:0] last_no;
    logic [SUM_W-1:0] lim;
    logic [KEY_W-1:0] ivl;
    logic [RC_W-1:0] cnt;
    fill_e mode;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values written back, plus the unused index
    write_regs(SSE_LIMIT_RESET, KEY_INTERVAL_RESET, REFERENCE_COUNT_RESET, 1'b1);

    // over-length frames: the first is kept, the second is compared to it
    send_frame(LONG_LEN, 32'd0, 32'd0, FILL_RANDOM);
    send_frame(LONG_LEN, 32'd1, 32'd1, FILL_RANDOM);
    settle();

    // directed: zero limit, every frame kept, one reference; all-zero frame,
    // exact repeat (zero difference is no movement), then all-full frame
    write_regs('0, '0, 3'd1, 1'b0);
    send_frame(FRAME_CAP, 32'd20, 32'd20, FILL_LOW);
    send_frame(FRAME_CAP, 32'd21, 32'd21, FILL_REPEAT);
    send_frame(FRAME_CAP, 32'd22, 32'd22, FILL_HIGH);
    fnum_now = 32'd22;

    // random phases, one register setting and one pacing mode each
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       begin lim = '0;                 ivl = '0;       cnt = 3'd7; end
        1:       begin lim = SUM_MAX;            ivl = 16'd1;    cnt = 3'd1; end
        2:       begin lim = 28'd5;              ivl = 16'd3;    cnt = 3'd4; end
        3:       begin lim = SSE_LIMIT_RESET;    ivl = 16'hFFFF; cnt = 3'd0; end
        4:       begin lim = SUM_W'($urandom_range(20)); ivl = 16'd2;  cnt = 3'd3; end
        5:       begin lim = SUM_W'($urandom_range(20)); ivl = '0;     cnt = 3'd5; end
        6:       begin lim = 28'd12;             ivl = 16'd1;    cnt = 3'd2; end
        default: begin lim = SUM_W'($urandom_range(20)); ivl = 16'd40; cnt = 3'd4; end
      endcase
      case (pace_e'(ph % 4))
        PACE_FULL:        begin gap_pct = 0;  stall_pct <= 0;  end
        PACE_SEND_GAPS:   begin gap_pct = 72; stall_pct <= 0;  end
        PACE_RECV_STALLS: begin gap_pct = 0;  stall_pct <= 72; end
        default:          begin gap_pct = 22; stall_pct <= 22; end
      endcase
      // jump past any long key interval; the last phase runs near the top
      // of the frame index range so the next key index wraps
      if (ph == PHASES - 1) fnum_now = 32'hFFFF_FFD8 + $urandom_range(8);
      else fnum_now = sat_add(fnum_now, $urandom_range(70000));
      write_regs(lim, ivl, cnt, ph == 5);

      mark = pixels_sent;
      while (pixels_sent - mark < PHASE_ITEMS) begin
        first_no = sat_add(fnum_now, $urandom_range(3));
        last_no  = first_no;
        if ($urandom_range(9) == 0) last_no = sat_add(first_no, $urandom_range(2, 1));
        fnum_now = last_no;
        roll = $urandom_range(99);
        if (roll < 10)      mode = FILL_RANDOM;
        else if (roll < 20) mode = FILL_EXTREME;
        else if (roll < 55) mode = FILL_REPEAT;
        else                mode = FILL_NUDGE;
        send_frame(0, first_no, last_no, mode);
      end
    end

    gap_pct = 0;
    stall_pct <= 0;
    settle();

    $display("summary: %0d pixels in %0d frames (two over-length) under %0d register settings",
             pixels_sent, frames_sent, settings);
    $display("summary: %0d verdicts compared, %0d with movement, %0d kept as key frames",
             judged, moved_seen, keys_seen);
    if (errors == 0 && pending == 0) begin
      $display("keyframe_psnr_motion_detector_tb: done, clean");
    end else begin
      $display("keyframe_psnr_motion_detector_tb: done, errors");
    end
    $finish;
  end

endmodule
